// ===== hdl/dtg_pkg.sv =====
// Shared constants, types and wave table function for the DDS tone generator.
`default_nettype none

package dtg_pkg;

  // Data widths
  localparam int PHASE_W       = 32;
  localparam int AMP_W         = 7;
  localparam int SAMPLE_W      = 16;
  localparam int ENV_FRAC_BITS = 16;
  localparam int ENV_W         = AMP_W + ENV_FRAC_BITS;
  localparam int TABLE_ENTRIES = 256;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int FRAC_LSB      = PHASE_W - 2 * ADDR_W;
  localparam int MAG_W         = 15;
  localparam int PROD_W        = MAG_W + ENV_W;
  localparam int SCALED_W      = PROD_W - ENV_FRAC_BITS;

  // Envelope smoothing coefficient, alpha in Q16
  localparam int ALPHA_W    = 10;
  localparam int ALPHA_FRAC = 16;
  localparam logic [ALPHA_W-1:0] SMOOTH_COEF = ALPHA_W'(655);

  // Division by full scale level through a reciprocal multiply
  localparam int ENV_FULL     = 127;
  localparam int RECIP_SHIFT  = 30;
  localparam int RECIP_W      = 24;
  localparam logic [RECIP_W-1:0] ENV_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + ENV_FULL - 1) / ENV_FULL);

  // Waveform codes
  typedef logic [1:0] wave_t;
  localparam wave_t WAVE_SINE     = 2'd0;
  localparam wave_t WAVE_SQUARE   = 2'd1;
  localparam wave_t WAVE_TRIANGLE = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] WAVE_PEAK = 16'sd32000;

  localparam logic signed [SAMPLE_W-1:0] QUARTER_SINE [0:64] = '{
    16'sd0,     16'sd785,   16'sd1570,  16'sd2354,  16'sd3136,
    16'sd3917,  16'sd4695,  16'sd5470,  16'sd6242,  16'sd7011,
    16'sd7775,  16'sd8534,  16'sd9289,  16'sd10037, 16'sd10780,
    16'sd11516, 16'sd12245, 16'sd12967, 16'sd13681, 16'sd14387,
    16'sd15084, 16'sd15772, 16'sd16451, 16'sd17119, 16'sd17778,
    16'sd18425, 16'sd19062, 16'sd19687, 16'sd20300, 16'sd20901,
    16'sd21489, 16'sd22065, 16'sd22627, 16'sd23175, 16'sd23710,
    16'sd24230, 16'sd24736, 16'sd25227, 16'sd25702, 16'sd26162,
    16'sd26607, 16'sd27035, 16'sd27447, 16'sd27842, 16'sd28221,
    16'sd28583, 16'sd28927, 16'sd29254, 16'sd29564, 16'sd29855,
    16'sd30129, 16'sd30384, 16'sd30622, 16'sd30840, 16'sd31041,
    16'sd31222, 16'sd31385, 16'sd31528, 16'sd31653, 16'sd31759,
    16'sd31845, 16'sd31913, 16'sd31961, 16'sd31990, 16'sd32000
  };

  // Wave table entry for a given shape and index
  function automatic logic signed [SAMPLE_W-1:0] wave_entry(input wave_t shape,
                                                             input logic [7:0] idx);
    logic [7:0]                  h;
    logic [7:0]                  mirror;
    logic signed [SAMPLE_W-1:0]  q;
    int                          t;
    h      = {1'b0, idx[6:0]};
    mirror = 8'd128 - h;
    q      = (h <= 8'd64) ? QUARTER_SINE[h[6:0]] : QUARTER_SINE[mirror[6:0]];
    t      = (idx < 8'd128) ? (int'(idx) - 64) * 500 : (192 - int'(idx)) * 500;
    case (shape)
      WAVE_SQUARE:   wave_entry = idx[7] ? -WAVE_PEAK : WAVE_PEAK;
      WAVE_TRIANGLE: wave_entry = SAMPLE_W'(t);
      default:       wave_entry = idx[7] ? -q : q;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dtg_in_if.sv =====
// Request channel carrying a sample tick with phase increment and amplitude.
`default_nettype none

interface dtg_in_if;
  logic                          valid;
  logic                          ready;
  logic [dtg_pkg::PHASE_W-1:0]   phase_inc;
  logic [dtg_pkg::AMP_W-1:0]     target_amp;

  modport source (output valid, output phase_inc, output target_amp, input ready);
  modport sink   (input valid, input phase_inc, input target_amp, output ready);
endinterface

`default_nettype wire

// ===== hdl/dtg_out_if.sv =====
// Request channel carrying one signed PCM sample.
`default_nettype none

interface dtg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dtg_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/dds_tone_generator_with_envelope_top.sv =====
// DDS tone generator top level: phase accumulator, wave table RAM, envelope, scaling.
// Each request reads the single wave table RAM at the accepting edge, then its magnitude,
// product and sample are registered in turn; a new request is taken only once the last
// has left the divide step, which a full output register holds.
// Reset: synchronous, active low; clears phase, envelope, held increment and waveform, then
// fills all 256 table entries with sine, no request taken, as a waveform write does.
`default_nettype none

module dds_tone_generator_with_envelope_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_wdata,
  dtg_in_if.sink                            in_ch,
  dtg_out_if.source                         out_ch
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_INTERP = 4'b0010,
    S_SCALE  = 4'b0100,
    S_DIV    = 4'b1000
  } state_t;

  localparam int ENV_STEP_W = dtg_pkg::ENV_W + dtg_pkg::ALPHA_W + 1;
  localparam int QM_W       = dtg_pkg::SCALED_W + dtg_pkg::RECIP_W;

  state_t state_r, state_nxt;

  // Oscillator and envelope state
  logic [dtg_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [dtg_pkg::PHASE_W-1:0] held_inc_r, held_inc_nxt;
  logic [dtg_pkg::ENV_W-1:0]   env_r, env_nxt;
  logic                        tone_was_on_r;
  logic                        zero_r;

  // Wave table RAM and fill sweep
  logic signed [dtg_pkg::SAMPLE_W-1:0] wave_mem [0:dtg_pkg::TABLE_ENTRIES-1];
  logic signed [dtg_pkg::SAMPLE_W-1:0] rd0_r, rd1_r;
  dtg_pkg::wave_t                      waveform_r;
  logic                                fill_active_r;
  logic [dtg_pkg::ADDR_W-1:0]          fill_idx_r;

  // Datapath registers
  logic                               sign_r;
  logic [dtg_pkg::MAG_W-1:0]          mag_r;
  logic [dtg_pkg::PROD_W-1:0]         prod_r;
  logic                               out_valid_r;
  logic signed [dtg_pkg::SAMPLE_W-1:0] sample_r;

  // Accept-cycle signals
  logic                          accept;
  logic                          tone_on;
  logic                          phase_clr;
  logic [dtg_pkg::PHASE_W-1:0]   use_inc;
  logic [dtg_pkg::PHASE_W-1:0]   phase_base;
  logic                          use_zero;
  logic [dtg_pkg::ENV_W-1:0]     env_tgt;
  logic [dtg_pkg::ENV_W-1:0]     env_diff;
  logic [ENV_STEP_W-1:0]         env_mul;
  logic [ENV_STEP_W-1:0]         env_step;
  logic [dtg_pkg::ADDR_W-1:0]    rd_addr0, rd_addr1;

  // Interpolation signals
  logic signed [dtg_pkg::SAMPLE_W:0]     s_diff;
  logic signed [dtg_pkg::SAMPLE_W+9:0]   s_prod;
  logic signed [dtg_pkg::SAMPLE_W+9:0]   s_interp;
  logic signed [dtg_pkg::SAMPLE_W:0]     s_val;
  logic [dtg_pkg::SAMPLE_W:0]            s_abs;

  // Division signals
  logic [dtg_pkg::SCALED_W-1:0]  scaled;
  logic [QM_W-1:0]               qm;
  logic [dtg_pkg::MAG_W-1:0]     q_mag;
  logic                          out_free;

  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ch.ready;

  assign in_ch.ready   = (state_r == S_IDLE) && !fill_active_r;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = sample_r;

  // Work out the tone state, increment, envelope step, new phase and read addresses of a request
  always_comb begin
    tone_on    = (in_ch.phase_inc != '0) && (in_ch.target_amp != '0);
    phase_clr  = tone_on && !tone_was_on_r &&
                 (env_r < (dtg_pkg::ENV_W'(1) << (dtg_pkg::ENV_FRAC_BITS - 1)));
    use_inc    = tone_on ? in_ch.phase_inc : held_inc_r;
    use_zero   = (use_inc == '0);
    phase_base = phase_clr ? '0 : phase_r;
    phase_nxt  = phase_base + use_inc;
    held_inc_nxt = tone_on ? in_ch.phase_inc : held_inc_r;
    env_tgt    = tone_on ? {in_ch.target_amp, {dtg_pkg::ENV_FRAC_BITS{1'b0}}} : '0;
    if (env_tgt >= env_r) begin
      env_diff = env_tgt - env_r;
      env_mul  = ENV_STEP_W'(env_diff) * ENV_STEP_W'(dtg_pkg::SMOOTH_COEF);
      env_step = env_mul >> dtg_pkg::ALPHA_FRAC;
      env_nxt  = env_r + dtg_pkg::ENV_W'(env_step);
    end else begin
      env_diff = env_r - env_tgt;
      env_mul  = ENV_STEP_W'(env_diff) * ENV_STEP_W'(dtg_pkg::SMOOTH_COEF);
      env_step = (env_mul + ENV_STEP_W'((1 << dtg_pkg::ALPHA_FRAC) - 1))
                 >> dtg_pkg::ALPHA_FRAC;
      env_nxt  = env_r - dtg_pkg::ENV_W'(env_step);
    end
    if (use_zero) begin
      env_nxt   = '0;
      phase_nxt = phase_base;
    end
    rd_addr0 = phase_nxt[dtg_pkg::PHASE_W-1 -: dtg_pkg::ADDR_W];
    rd_addr1 = rd_addr0 + dtg_pkg::ADDR_W'(1);
  end

  // Interpolate between neighbouring entries, rounding toward minus infinity
  always_comb begin
    s_diff   = (dtg_pkg::SAMPLE_W+1)'(rd1_r) - (dtg_pkg::SAMPLE_W+1)'(rd0_r);
    s_prod   = (dtg_pkg::SAMPLE_W+10)'(s_diff) *
               $signed({2'b00, phase_r[dtg_pkg::FRAC_LSB +: dtg_pkg::ADDR_W]});
    s_interp = s_prod >>> dtg_pkg::ADDR_W;
    s_val    = (dtg_pkg::SAMPLE_W+1)'(rd0_r) + (dtg_pkg::SAMPLE_W+1)'(s_interp);
    s_abs    = s_val[dtg_pkg::SAMPLE_W] ? (dtg_pkg::SAMPLE_W+1)'(-s_val)
                                        : (dtg_pkg::SAMPLE_W+1)'(s_val);
  end

  // Divide the scaled magnitude by full scale through the reciprocal
  always_comb begin
    scaled = prod_r[dtg_pkg::PROD_W-1:dtg_pkg::ENV_FRAC_BITS];
    qm     = QM_W'(scaled) * QM_W'(dtg_pkg::ENV_RECIP);
    q_mag  = dtg_pkg::MAG_W'(qm >> dtg_pkg::RECIP_SHIFT);
  end

  // Sequence one request through read, interpolate, scale and divide
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_INTERP;
      S_INTERP: state_nxt = S_SCALE;
      S_SCALE:  state_nxt = S_DIV;
      S_DIV:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control state, oscillator state, waveform register, fill sweep and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      phase_r       <= '0;
      held_inc_r    <= '0;
      env_r         <= '0;
      tone_was_on_r <= 1'b0;
      waveform_r    <= dtg_pkg::WAVE_SINE;
      fill_active_r <= 1'b1;
      fill_idx_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        phase_r       <= phase_nxt;
        held_inc_r    <= held_inc_nxt;
        env_r         <= env_nxt;
        tone_was_on_r <= tone_on;
      end
      // Restart the fill sweep on a waveform write, else advance it
      if (cfg_we) begin
        waveform_r    <= cfg_wdata;
        fill_active_r <= 1'b1;
        fill_idx_r    <= '0;
      end else if (fill_active_r) begin
        fill_idx_r <= fill_idx_r + dtg_pkg::ADDR_W'(1);
        if (fill_idx_r == dtg_pkg::ADDR_W'(dtg_pkg::TABLE_ENTRIES - 1)) begin
          fill_active_r <= 1'b0;
        end
      end
      // Drop the output once taken, load it when the divide completes
      if (state_r == S_DIV && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Wave table RAM: one write port for the fill, two registered read ports
  always_ff @(posedge clk) begin
    if (fill_active_r) begin
      wave_mem[fill_idx_r] <= dtg_pkg::wave_entry(waveform_r, fill_idx_r);
    end
    rd0_r <= wave_mem[rd_addr0];
    rd1_r <= wave_mem[rd_addr1];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      zero_r <= use_zero;
    end
    if (state_r == S_INTERP) begin
      sign_r <= s_val[dtg_pkg::SAMPLE_W];
      mag_r  <= dtg_pkg::MAG_W'(s_abs);
    end
    if (state_r == S_SCALE) begin
      prod_r <= dtg_pkg::PROD_W'(mag_r) * dtg_pkg::PROD_W'(env_r);
    end
    if (state_r == S_DIV && out_free) begin
      if (zero_r) begin
        sample_r <= '0;
      end else if (sign_r) begin
        sample_r <= -$signed(dtg_pkg::SAMPLE_W'(q_mag));
      end else begin
        sample_r <= $signed(dtg_pkg::SAMPLE_W'(q_mag));
      end
    end
  end

endmodule

`default_nettype wire
